// ===== sv/crc_checked_frame_deframer_top_macros.svh =====
// Assertion macros shared by the deframer's checker.
// Each macro expands to one labelled concurrent assertion on a clock and reset.
`ifndef CRC_CHECKED_FRAME_DEFRAMER_TOP_MACROS_SVH
`define CRC_CHECKED_FRAME_DEFRAMER_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define CFD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Consequent checked in the cycle after the antecedent.
`define CFD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

// ===== sv/cfd_pkg.sv =====
// Shared types, constants and the CRC step for the frame deframer.
// Used by every module of the deframer but the frame RAM; depends on nothing else.
package cfd_pkg;

    // Frame length limits, in bytes, including the length byte itself.
    localparam int MAX_FRAME = 64;
    localparam int MIN_FRAME = 5;

    // Position within a frame, and a length that can hold MAX_FRAME.
    localparam int POS_W = $clog2(MAX_FRAME);
    localparam int LEN_W = $clog2(MAX_FRAME + 1);

    // Two frame banks: one being filled, one being replayed.
    localparam int RAM_AW    = POS_W + 1;
    localparam int RAM_DEPTH = 2 ** RAM_AW;

    // Command queue between the front and back ends.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] CRC_INIT = 16'hffff;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SYNC = 2'd0;
    localparam logic [1:0] CFG_DEST = 2'd1;
    localparam logic [1:0] CFG_MASK = 2'd2;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_GOOD    = 2'd0,
        KIND_CHECK   = 2'd1,
        KIND_FRAMING = 2'd2
    } kind_t;

    // One queued command: an error result or a good frame to replay.
    typedef struct packed {
        kind_t             kind;
        logic [LEN_W-1:0]  len;
        logic              bank;
        logic [15:0]       check_cnt;
        logic [15:0]       framing_cnt;
    } cmd_t;

    // Queue occupancy seen by the front and back ends.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // One byte step of the reflected CRC-16 (poly 0x8408).
    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = b ^ crc[7:0];
        v = v ^ {v[3:0], 4'b0000};
        return {v, crc[15:8]} ^ {12'h000, v[7:4]} ^ {5'b00000, v, 3'b000};
    endfunction

endpackage

// ===== sv/cfd_frame_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
// Stands alone; holds the frame bytes for the deframer.
module cfd_frame_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/cfd_cmd_queue.sv =====
// Short command queue between the deframer's front and back ends.
// Depends on cfd_pkg for the command type and depth.
module cfd_cmd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  cfd_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output cfd_pkg::cmd_t      head,
    output cfd_pkg::q_status_t status
);
    import cfd_pkg::*;

    cmd_t                entry [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_CW-1:0] count_next;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + QUEUE_AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + QUEUE_AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QUEUE_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head         = entry[rd_ptr_reg];
    assign status.full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

// ===== sv/cfd_front.sv =====
// Front end of the deframer: takes link bytes, tracks framing and CRC,
// stores frame bytes and queues one command per finished frame or error.
// Depends on cfd_pkg.
module cfd_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    input  logic [1:0]                 cfg_index,
    input  logic [7:0]                 cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 in_byte,
    input  cfd_pkg::q_status_t         q_status,
    input  logic                       pop_good,
    output logic                       push,
    output cfd_pkg::cmd_t              push_cmd,
    output logic                       ram_we,
    output logic [cfd_pkg::RAM_AW-1:0] ram_waddr,
    output logic [7:0]                 ram_wdata
);
    import cfd_pkg::*;

    logic [7:0]       sync_reg;
    logic [7:0]       dest_reg;
    logic [7:0]       mask_reg;
    logic             hunting_reg;
    logic             hunting_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [15:0]      crc_reg;
    logic [15:0]      crc_next;
    logic [7:0]       byte1_reg;
    logic [7:0]       byte1_next;
    logic [7:0]       crc_hi_reg;
    logic [7:0]       crc_hi_next;
    logic [7:0]       crc_lo_reg;
    logic [7:0]       crc_lo_next;
    logic [15:0]      check_reg;
    logic [15:0]      check_next;
    logic [15:0]      framing_reg;
    logic [15:0]      framing_next;
    logic             bank_reg;
    logic             bank_next;
    logic [1:0]       good_out_reg;
    logic [1:0]       good_out_next;
    logic             accept;
    logic             push_good;
    logic             frame_ok;
    logic [LEN_W-1:0] pos_ext;
    kind_t            cmd_kind;

    // Hold input while the queue is full or both banks await replay.
    assign in_stall = q_status.full || (good_out_reg == 2'd2);
    assign accept   = in_valid && !in_stall;
    assign pos_ext  = LEN_W'(pos_reg);

    assign frame_ok = (in_byte == sync_reg)
                   && ((byte1_reg & ~mask_reg) == dest_reg)
                   && ({crc_hi_reg, crc_lo_reg} == crc_reg);

    // Per-byte framing, check and command decisions.
    always_comb
    begin
        hunting_next = hunting_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;
        crc_next     = crc_reg;
        byte1_next   = byte1_reg;
        crc_hi_next  = crc_hi_reg;
        crc_lo_next  = crc_lo_reg;
        check_next   = check_reg;
        framing_next = framing_reg;
        bank_next    = bank_reg;
        push         = 1'b0;
        push_good    = 1'b0;
        cmd_kind     = KIND_GOOD;
        ram_we       = 1'b0;
        if (accept)
        begin
            if (hunting_reg)
            begin
                if (in_byte == sync_reg)
                begin
                    hunting_next = 1'b0;
                end
            end
            else if (pos_reg == '0)
            begin
                if ((in_byte < 8'(MIN_FRAME)) || (in_byte > 8'(MAX_FRAME)))
                begin
                    framing_next = framing_reg + 16'd1;
                    push         = 1'b1;
                    cmd_kind     = KIND_FRAMING;
                    hunting_next = (in_byte != sync_reg);
                end
                else
                begin
                    ram_we   = 1'b1;
                    len_next = LEN_W'(in_byte);
                    crc_next = crc_add(CRC_INIT, in_byte);
                    pos_next = POS_W'(1);
                end
            end
            else
            begin
                ram_we = 1'b1;
                if (pos_ext <= len_reg - LEN_W'(4))
                begin
                    crc_next = crc_add(crc_reg, in_byte);
                end
                if (pos_reg == POS_W'(1))
                begin
                    byte1_next = in_byte;
                end
                if (pos_ext == len_reg - LEN_W'(3))
                begin
                    crc_hi_next = in_byte;
                end
                if (pos_ext == len_reg - LEN_W'(2))
                begin
                    crc_lo_next = in_byte;
                end
                if (pos_ext == len_reg - LEN_W'(1))
                begin
                    pos_next = '0;
                    crc_next = CRC_INIT;
                    push     = 1'b1;
                    if (frame_ok)
                    begin
                        push_good = 1'b1;
                        bank_next = ~bank_reg;
                    end
                    else
                    begin
                        check_next   = check_reg + 16'd1;
                        cmd_kind     = KIND_CHECK;
                        hunting_next = (in_byte != sync_reg);
                    end
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
        good_out_next = good_out_reg + {1'b0, push_good} - {1'b0, pop_good};
    end

    assign push_cmd.kind        = cmd_kind;
    assign push_cmd.len         = len_reg;
    assign push_cmd.bank        = bank_reg;
    assign push_cmd.check_cnt   = check_next;
    assign push_cmd.framing_cnt = framing_next;

    assign ram_waddr = {bank_reg, pos_reg};
    assign ram_wdata = in_byte;

    // Control state and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg     <= 8'd126;
            dest_reg     <= 8'd16;
            mask_reg     <= 8'd15;
            hunting_reg  <= 1'b0;
            pos_reg      <= '0;
            crc_reg      <= CRC_INIT;
            check_reg    <= '0;
            framing_reg  <= '0;
            bank_reg     <= 1'b0;
            good_out_reg <= '0;
        end
        else
        begin
            hunting_reg  <= hunting_next;
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            check_reg    <= check_next;
            framing_reg  <= framing_next;
            bank_reg     <= bank_next;
            good_out_reg <= good_out_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_SYNC: sync_reg <= cfg_data;
                    CFG_DEST: dest_reg <= cfg_data;
                    CFG_MASK: mask_reg <= cfg_data;
                    default:  ;
                endcase
            end
        end
    end

    // Frame fields captured as they pass.
    always_ff @(posedge clk)
    begin
        len_reg    <= len_next;
        byte1_reg  <= byte1_next;
        crc_hi_reg <= crc_hi_next;
        crc_lo_reg <= crc_lo_next;
    end

endmodule

// ===== sv/cfd_back.sv =====
// Back end of the deframer: turns queued commands into result items,
// replaying good frames from the frame RAM one byte per cycle while the
// output is not stalled. Depends on cfd_pkg.
module cfd_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfd_pkg::cmd_t              head,
    input  cfd_pkg::q_status_t         q_status,
    output logic                       pop,
    output logic                       pop_good,
    output logic                       ram_re,
    output logic [cfd_pkg::RAM_AW-1:0] ram_raddr,
    input  logic [7:0]                 ram_rdata,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [1:0]                 kind,
    output logic [7:0]                 frame_byte,
    output logic [5:0]                 byte_index,
    output logic                       last,
    output logic [15:0]                check_errors,
    output logic [15:0]                length_errors
);
    import cfd_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    logic [POS_W-1:0] idx_reg;
    logic [POS_W-1:0] idx_next;
    kind_t            kind_reg;
    kind_t            kind_next;
    logic [5:0]       index_reg;
    logic [5:0]       index_next;
    logic             last_reg;
    logic             last_next;
    logic [15:0]      check_reg;
    logic [15:0]      check_next;
    logic [15:0]      framing_reg;
    logic [15:0]      framing_next;
    logic             load;
    logic             frame_end;

    // The output register takes a new item when empty or being drained.
    assign load      = !valid_reg || !out_stall;
    assign frame_end = (LEN_W'(idx_reg) == head.len - LEN_W'(1));

    always_comb
    begin
        valid_next   = valid_reg;
        idx_next     = idx_reg;
        kind_next    = kind_reg;
        index_next   = index_reg;
        last_next    = last_reg;
        check_next   = check_reg;
        framing_next = framing_reg;
        pop          = 1'b0;
        pop_good     = 1'b0;
        ram_re       = 1'b0;
        if (load)
        begin
            if (q_status.empty)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                valid_next   = 1'b1;
                kind_next    = head.kind;
                check_next   = head.check_cnt;
                framing_next = head.framing_cnt;
                if (head.kind == KIND_GOOD)
                begin
                    ram_re     = 1'b1;
                    index_next = 6'(idx_reg);
                    last_next  = frame_end;
                    if (frame_end)
                    begin
                        pop      = 1'b1;
                        pop_good = 1'b1;
                        idx_next = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + POS_W'(1);
                    end
                end
                else
                begin
                    index_next = '0;
                    last_next  = 1'b1;
                    pop        = 1'b1;
                end
            end
        end
    end

    assign ram_raddr = {head.bank, idx_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Output payload, loaded alongside the RAM read.
    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        index_reg   <= index_next;
        last_reg    <= last_next;
        check_reg   <= check_next;
        framing_reg <= framing_next;
    end

    assign out_valid     = valid_reg;
    assign kind          = kind_reg;
    assign frame_byte    = (kind_reg == KIND_GOOD) ? ram_rdata : 8'd0;
    assign byte_index    = index_reg;
    assign last          = last_reg;
    assign check_errors  = check_reg;
    assign length_errors = framing_reg;

endmodule

// ===== sv/crc_checked_frame_deframer_top.sv =====
// Length-prefixed frame deframer with CRC-16 check. One received byte is
// accepted per clock cycle while input is not stalled; each good frame is
// replayed as one result item per clock, while the output is not stalled,
// from a two-bank frame RAM, and each length or check failure gives a single
// error item. The front end stalls input only while the four-entry command
// queue is full or both RAM banks hold frames that still await replay. A
// frame's first result passes through the command queue and then the output
// register. No clearing pass is needed after reset.
module crc_checked_frame_deframer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  frame_byte,
    output logic [5:0]  byte_index,
    output logic        last,
    output logic [15:0] check_errors,
    output logic [15:0] length_errors
);
    import cfd_pkg::*;

    q_status_t         q_status;
    cmd_t              push_cmd;
    cmd_t              head;
    logic              push;
    logic              pop;
    logic              pop_good;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [RAM_AW-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    // Register writes are always taken.
    assign cfg_ready = 1'b1;

    cfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .q_status  (q_status),
        .pop_good  (pop_good),
        .push      (push),
        .push_cmd  (push_cmd),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    cfd_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    cfd_frame_ram #(
        .DEPTH (RAM_DEPTH),
        .WIDTH (8),
        .AW    (RAM_AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cfd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_status      (q_status),
        .pop           (pop),
        .pop_good      (pop_good),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .frame_byte    (frame_byte),
        .byte_index    (byte_index),
        .last          (last),
        .check_errors  (check_errors),
        .length_errors (length_errors)
    );

endmodule

// ===== sv/cfd_checker.sv =====
// Port-level checker for the deframer, bound to the top level.
// Depends on cfd_pkg and the assertion macro header.
`include "crc_checked_frame_deframer_top_macros.svh"

module cfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  kind,
    input logic [7:0]  frame_byte,
    input logic [5:0]  byte_index,
    input logic        last
);
    import cfd_pkg::*;

    // A stalled result item holds its payload.
    `CFD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(kind) && $stable(frame_byte) && $stable(byte_index) && $stable(last))

    // An error item is a lone, final item with no frame data.
    `CFD_ASSERT_NOW(a_err_shape, clk, rst_n, out_valid && (kind != KIND_GOOD), last && (frame_byte == 8'd0) && (byte_index == 6'd0))

    // Within a good frame the bytes follow one another without gaps.
    `CFD_ASSERT_NEXT(a_frame_seq, clk, rst_n, out_valid && !out_stall && (kind == KIND_GOOD) && !last, out_valid && (kind == KIND_GOOD) && (byte_index == 6'($past(byte_index) + 6'd1)))

    // After a final item the next one starts at position zero.
    `CFD_ASSERT_NEXT(a_frame_start, clk, rst_n, out_valid && !out_stall && last, !out_valid || (byte_index == 6'd0))

endmodule

bind crc_checked_frame_deframer_top cfd_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .frame_byte (frame_byte),
    .byte_index (byte_index),
    .last       (last)
);

// ===== sim/tb_top.sv =====
// Self-checking bench for crc_checked_frame_deframer_top: builds framed byte streams,
// predicts every result item, and compares them as they leave the deframer.
// Depends on cfd_pkg for the frame limits, register indexes and result kinds.
`timescale 1ns / 100ps

module tb_top;
    import cfd_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_BYTES  = 200;
    localparam int BURST_FRAMES  = 3;

    // One predicted result item.
    typedef struct {
        kind_t       kind;
        logic [7:0]  fbyte;
        logic [5:0]  idx;
        logic        lst;
        logic [15:0] chk;
        logic [15:0] frm;
    } deframe_result_t;

    // Stimulus actions: a byte, a register write, a pause, or quiet mode on or off.
    typedef enum logic [2:0] {
        ACT_BYTE,
        ACT_CFG,
        ACT_DRAIN,
        ACT_QUIET_ON,
        ACT_QUIET_OFF
    } action_op_t;

    typedef struct {
        action_op_t op;
        logic [1:0] idx;
        logic [7:0] value;
    } stim_action_t;

    typedef enum logic [2:0] {
        FAULT_NONE,
        FAULT_SYNC,
        FAULT_DEST,
        FAULT_CRC,
        FAULT_LEN
    } frame_fault_t;

    // Block ports.
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = CFG_SYNC;
    logic [7:0]  cfg_data  = 8'h00;
    logic        in_valid  = 1'b0;
    logic [7:0]  in_byte   = 8'h00;
    logic        out_stall = 1'b0;
    logic        cfg_ready;
    logic        in_stall;
    logic        out_valid;
    logic [1:0]  kind;
    logic [7:0]  frame_byte;
    logic [5:0]  byte_index;
    logic        last;
    logic [15:0] check_errors;
    logic [15:0] length_errors;

    // Predicted deframer state and register copies.
    logic        hunt_st;
    int          fill_cnt;
    logic [7:0]  frame_buf [0:MAX_FRAME-1];
    logic [15:0] crc_acc;
    logic [15:0] chk_count;
    logic [15:0] frm_count;
    logic [7:0]  sync_reg;
    logic [7:0]  dest_reg;
    logic [7:0]  mask_reg;

    // Register values as seen by the stimulus builder.
    logic [7:0]  gen_sync = 8'd126;
    logic [7:0]  gen_dest = 8'd16;
    logic [7:0]  gen_mask = 8'd15;

    deframe_result_t pending_results [$];
    stim_action_t    stim_actions [$];

    // Driver and monitor bookkeeping.
    stim_action_t cur_action;
    logic         have_action = 1'b0;
    int           hold_left   = 0;
    logic         drv_in_valid;
    logic         drv_cfg_valid;
    logic         stim_done   = 1'b0;
    bit           quiet       = 1'b0;
    bit           send_free   = 1'b0;
    bit           recv_free   = 1'b0;
    int           stall_left  = 0;
    int           mismatches  = 0;
    deframe_result_t want;

    crc_checked_frame_deframer_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .frame_byte    (frame_byte),
        .byte_index    (byte_index),
        .last          (last),
        .check_errors  (check_errors),
        .length_errors (length_errors)
    );

    // Clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Reflected CRC-16, polynomial 0x8408, one bit at a time.
    function automatic logic [15:0] crc16_mcrf_step(input logic [15:0] acc,
                                                    input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
        return c;
    endfunction

    // Wait drawn per item; each side toggles between idling and running free.
    function automatic int draw_wait(inout bit free_run);
        if ($urandom_range(0, 31) == 0)
            free_run = !free_run;
        if (quiet || free_run)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    function automatic void queue_result(input kind_t k, input logic [7:0] b,
                                         input logic [5:0] i, input logic l);
        deframe_result_t r;
        r.kind  = k;
        r.fbyte = b;
        r.idx   = i;
        r.lst   = l;
        r.chk   = chk_count;
        r.frm   = frm_count;
        pending_results.push_back(r);
    endfunction

    function automatic void restart_frame();
        fill_cnt = 0;
        crc_acc  = CRC_INIT;
    endfunction

    // Predicts the result items caused by one accepted byte.
    function automatic void deframe_byte(input logic [7:0] b);
        int   flen;
        logic good;
        if (hunt_st)
        begin
            if (b == sync_reg)
                hunt_st = 1'b0;
            return;
        end
        if (fill_cnt >= MAX_FRAME)
        begin
            frm_count++;
            restart_frame();
            hunt_st = 1'b1;
            queue_result(KIND_FRAMING, 8'h00, 6'd0, 1'b1);
            return;
        end
        frame_buf[fill_cnt] = b;
        fill_cnt++;
        flen = frame_buf[0];
        if (flen < MIN_FRAME || flen > MAX_FRAME)
        begin
            frm_count++;
            restart_frame();
            hunt_st = (b != sync_reg);
            queue_result(KIND_FRAMING, 8'h00, 6'd0, 1'b1);
            return;
        end
        if (fill_cnt <= flen - 3)
            crc_acc = crc16_mcrf_step(crc_acc, b);
        if (fill_cnt < flen)
            return;
        good = (frame_buf[flen-1] == sync_reg)
            && ((frame_buf[1] & ~mask_reg) == dest_reg)
            && ({frame_buf[flen-3], frame_buf[flen-2]} == crc_acc);
        restart_frame();
        if (!good)
        begin
            chk_count++;
            hunt_st = (b != sync_reg);
            queue_result(KIND_CHECK, 8'h00, 6'd0, 1'b1);
            return;
        end
        for (int i = 0; i < flen; i++)
            queue_result(KIND_GOOD, frame_buf[i], 6'(i), i == flen - 1);
    endfunction

    // Stimulus builders.
    function automatic void push_byte(input logic [7:0] b);
        stim_action_t a;
        a.op    = ACT_BYTE;
        a.idx   = CFG_SYNC;
        a.value = b;
        stim_actions.push_back(a);
    endfunction

    function automatic void push_op(input action_op_t op);
        stim_action_t a;
        a.op    = op;
        a.idx   = CFG_SYNC;
        a.value = 8'h00;
        stim_actions.push_back(a);
    endfunction

    function automatic void push_cfg(input logic [1:0] idx, input logic [7:0] v);
        stim_action_t a;
        a.op    = ACT_CFG;
        a.idx   = idx;
        a.value = v;
        stim_actions.push_back(a);
        case (idx)
            CFG_SYNC: gen_sync = v;
            CFG_DEST: gen_dest = v;
            default:  gen_mask = v;
        endcase
    endfunction

    // A frame of the given length, well formed apart from the chosen fault.
    // Faults that leave the deframer hunting are followed by the sync byte.
    function automatic void push_frame(input int len, input frame_fault_t fault);
        logic [7:0]  fb [0:MAX_FRAME-1];
        logic [7:0]  junk;
        logic [15:0] crc;
        int          bitn;
        int          njunk;
        if (fault == FAULT_LEN)
        begin
            fb[0] = $urandom_range(0, 1) ? 8'($urandom_range(0, MIN_FRAME - 1))
                                         : 8'($urandom_range(MAX_FRAME + 1, 255));
            push_byte(fb[0]);
            if (fb[0] != gen_sync)
            begin
                njunk = $urandom_range(0, 3);
                for (int i = 0; i < njunk; i++)
                begin
                    do junk = 8'($urandom); while (junk == gen_sync);
                    push_byte(junk);
                end
                push_byte(gen_sync);
            end
            return;
        end
        if (fault == FAULT_DEST && gen_mask == 8'hff)
            fault = FAULT_CRC;
        fb[0] = 8'(len);
        fb[1] = (gen_dest & ~gen_mask) | (8'($urandom) & gen_mask);
        if (fault == FAULT_DEST)
        begin
            do bitn = $urandom_range(0, 7); while (gen_mask[bitn]);
            fb[1][bitn] = ~fb[1][bitn];
        end
        for (int i = 2; i < len - 3; i++)
            fb[i] = 8'($urandom);
        crc = CRC_INIT;
        for (int i = 0; i < len - 3; i++)
            crc = crc16_mcrf_step(crc, fb[i]);
        if (fault == FAULT_CRC)
            crc[$urandom_range(0, 15)] ^= 1'b1;
        fb[len-3] = crc[15:8];
        fb[len-2] = crc[7:0];
        fb[len-1] = gen_sync;
        if (fault == FAULT_SYNC)
            fb[len-1] = gen_sync ^ 8'($urandom_range(1, 255));
        for (int i = 0; i < len; i++)
            push_byte(fb[i]);
        if (fault == FAULT_SYNC)
            push_byte(gen_sync);
    endfunction

    // Sender: takes actions from the queue and updates the prediction on acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            cfg_valid <= 1'b0;
        end
        else
        begin
            drv_in_valid  = in_valid;
            drv_cfg_valid = cfg_valid;
            if (in_valid && !in_stall)
            begin
                deframe_byte(in_byte);
                drv_in_valid = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SYNC: sync_reg = cfg_data;
                    CFG_DEST: dest_reg = cfg_data;
                    CFG_MASK: mask_reg = cfg_data;
                    default: ;
                endcase
                drv_cfg_valid = 1'b0;
            end
            if (!drv_in_valid && !drv_cfg_valid)
            begin
                if (!have_action && stim_actions.size() != 0)
                begin
                    cur_action  = stim_actions.pop_front();
                    have_action = 1'b1;
                    hold_left   = (cur_action.op == ACT_BYTE) ? draw_wait(send_free)
                                                              : SETTLE_CYCLES;
                end
                if (have_action)
                begin
                    case (cur_action.op)
                        ACT_BYTE:
                            if (hold_left != 0)
                                hold_left--;
                            else
                            begin
                                drv_in_valid = 1'b1;
                                in_byte     <= cur_action.value;
                                have_action  = 1'b0;
                            end
                        ACT_QUIET_ON:
                        begin
                            quiet       = 1'b1;
                            have_action = 1'b0;
                        end
                        ACT_QUIET_OFF:
                        begin
                            quiet       = 1'b0;
                            have_action = 1'b0;
                        end
                        default:
                            // Register writes and pauses wait for the block to drain.
                            if (pending_results.size() != 0)
                                hold_left = SETTLE_CYCLES;
                            else if (hold_left != 0)
                                hold_left--;
                            else
                            begin
                                if (cur_action.op == ACT_CFG)
                                begin
                                    drv_cfg_valid = 1'b1;
                                    cfg_index    <= cur_action.idx;
                                    cfg_data     <= cur_action.value;
                                end
                                have_action = 1'b0;
                            end
                    endcase
                end
                else
                    stim_done = 1'b1;
            end
            in_valid  <= drv_in_valid;
            cfg_valid <= drv_cfg_valid;
        end
    end

    // Receiver: random stalls, and a comparison of every accepted result item.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: kind %0d byte %02h index %0d last %0b",
                                 kind, frame_byte, byte_index, last);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (kind !== want.kind || frame_byte !== want.fbyte
                        || byte_index !== want.idx || last !== want.lst
                        || check_errors !== want.chk || length_errors !== want.frm)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("mismatch expected: kind %0d byte %02h index %0d last %0b chk %0d frm %0d",
                                     want.kind, want.fbyte, want.idx, want.lst, want.chk,
                                     want.frm);
                            $display("mismatch actual:   kind %0d byte %02h index %0d last %0b chk %0d frm %0d",
                                     kind, frame_byte, byte_index, last, check_errors,
                                     length_errors);
                        end
                    end
                end
                stall_left = draw_wait(recv_free);
            end
            else if (stall_left != 0)
                stall_left--;
            out_stall <= (stall_left != 0);
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int           sel;
        int           len;
        frame_fault_t fault;
        logic [7:0]   m;

        hunt_st   = 1'b0;
        chk_count = 16'd0;
        frm_count = 16'd0;
        sync_reg  = 8'd126;
        dest_reg  = 8'd16;
        mask_reg  = 8'd15;
        restart_frame();
        for (int i = 0; i < MAX_FRAME; i++)
            frame_buf[i] = 8'h00;

        // Directed: shortest and longest frames, bad lengths, hunting, each check fault.
        push_frame(MIN_FRAME, FAULT_NONE);
        push_frame(MAX_FRAME, FAULT_NONE);
        push_byte(8'h00);
        push_byte(8'hff);
        push_byte(gen_sync);
        push_byte(8'(MIN_FRAME - 1));
        push_byte(gen_sync);
        push_byte(8'(MAX_FRAME + 1));
        push_byte(gen_sync);
        push_byte(gen_sync);
        push_frame(6, FAULT_SYNC);
        push_frame(7, FAULT_DEST);
        push_frame(8, FAULT_CRC);
        push_op(ACT_DRAIN);
        push_frame(MIN_FRAME, FAULT_NONE);
        push_cfg(CFG_MASK, 8'hff);
        push_cfg(CFG_DEST, 8'h00);
        push_cfg(CFG_SYNC, 8'hff);
        push_frame(MIN_FRAME, FAULT_NONE);
        push_byte(8'hff);
        push_cfg(CFG_MASK, 8'h00);
        push_cfg(CFG_DEST, 8'hff);
        push_cfg(CFG_SYNC, 8'h00);
        push_frame(9, FAULT_NONE);
        push_frame(9, FAULT_DEST);

        // A short burst of frames with no idling on either side.
        push_op(ACT_QUIET_ON);
        for (int i = 0; i < BURST_FRAMES; i++)
            push_frame(8, FAULT_NONE);
        push_op(ACT_QUIET_OFF);

        // Random phases, each under a fresh register setting.
        for (int ph = 0; ph < 4; ph++)
        begin
            case ($urandom_range(0, 3))
                0:       push_cfg(CFG_SYNC, 8'h00);
                1:       push_cfg(CFG_SYNC, 8'hff);
                2:       push_cfg(CFG_SYNC, 8'($urandom_range(MAX_FRAME + 1, 254)));
                default: push_cfg(CFG_SYNC, 8'($urandom_range(0, MIN_FRAME - 1)));
            endcase
            m = (ph == 0) ? 8'h00 : (ph == 1) ? 8'hff : 8'($urandom);
            push_cfg(CFG_MASK, m);
            push_cfg(CFG_DEST, 8'($urandom) & ~m);
            for (int n = 0; n < RANDOM_BYTES / 4; )
            begin
                sel = $urandom_range(0, 99);
                if (sel < 8)
                begin
                    push_byte(8'($urandom));
                    n++;
                end
                else if (sel < 11)
                    push_op(ACT_DRAIN);
                else
                begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, MAX_FRAME)
                                                      : $urandom_range(MIN_FRAME, 12);
                    if (sel < 65)      fault = FAULT_NONE;
                    else if (sel < 73) fault = FAULT_SYNC;
                    else if (sel < 81) fault = FAULT_DEST;
                    else if (sel < 90) fault = FAULT_CRC;
                    else               fault = FAULT_LEN;
                    push_frame(len, fault);
                    n += (fault == FAULT_LEN) ? 2 : len;
                end
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (!stim_done)
            @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
